FILE: hdl/ffba_pkg.sv
package ffba_pkg;

    localparam int HEAP_BYTES_DEF   = 1048576;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_BLOCKS_DEF   = 64;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // classified request passed from the front to the back
    typedef struct packed {
        logic        is_free;
        logic        valid_op;
        logic [21:0] need;
        logic [31:0] rel;
    } ffba_cmd_t;

endpackage

FILE: hdl/ffba_front.sv
module ffba_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         heap_start,
    input  logic                valid,
    output logic                ready,
    input  logic                func,
    input  logic [20:0]         request_size,
    input  logic [31:0]         free_address,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output ffba_pkg::ffba_cmd_t cmd
);

    // two-entry queue of classified requests
    ffba_pkg::ffba_cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    ffba_pkg::ffba_cmd_t c;
    logic push, pop;

    assign ready     = (cnt_reg != 2'd2);
    assign push      = valid && ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    // classify the request
    always_comb
    begin
        c.is_free  = (func == ffba_pkg::FUNC_FREE);
        c.need     = ({1'b0, request_size} + 22'd15) & ~22'd15;
        c.rel      = free_address - heap_start;
        c.valid_op = c.is_free ? (free_address != 32'd0) : (request_size != 21'd0);
    end

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= c;
    end

endmodule

FILE: hdl/ffba_back.sv
module ffba_back
#(
    parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         heap_start,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ffba_pkg::ffba_cmd_t cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         result_address,
    output logic                ok,
    output logic [20:0]         used_bytes,
    output logic [20:0]         free_bytes
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);
    localparam logic [31:0] SPLIT_MIN = 32'(HEADER_BYTES + 16);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [1:0] JOB_NONE       = 2'd0;
    localparam logic [1:0] JOB_OPEN       = 2'd1;
    localparam logic [1:0] JOB_MERGE_NEXT = 2'd2;

    // row of cells, each holding one table entry
    logic [31:0] off_reg [MAX_BLOCKS];
    logic [31:0] sz_reg  [MAX_BLOCKS];
    logic        fr_reg  [MAX_BLOCKS];
    logic [CW-1:0] count_reg;
    logic [20:0] used_reg, avail_reg;
    logic [2:0]  state_reg;
    ffba_pkg::ffba_cmd_t cmd_reg;

    // per-cell match and first-match search
    logic [MAX_BLOCKS-1:0] hit;
    logic [MAX_BLOCKS-1:0] hit_first;
    logic [IW-1:0]         idx_reg;
    logic                  found_reg;
    logic [31:0]           addr_reg;
    logic                  ok_reg;
    logic                  ov_reg;

    // result held for the receiver
    logic [31:0] res_addr_reg;
    logic        res_ok_reg;
    logic [20:0] res_used_reg;
    logic [20:0] res_free_reg;
    logic        out_load;

    // shift job: open at idx+1 or merge the next entry; job2 merges into the previous
    logic [1:0]  job_reg;
    logic        job2_reg;

    // remainder of a split block, kept from the apply step
    logic [31:0] split_rem_reg;

    logic [31:0] need32;
    assign need32 = {10'd0, cmd_reg.need};

    always_comb
    begin
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            if (CW'(k) >= count_reg)
                hit[k] = 1'b0;
            else if (cmd_reg.is_free)
                hit[k] = !fr_reg[k] && ((off_reg[k] + HDR) == cmd_reg.rel);
            else
                hit[k] = fr_reg[k] && (sz_reg[k] >= need32);
        end
        hit_first = hit & ~(hit - 1'b1);
    end

    assign cmd_ready      = (state_reg == S_IDLE);
    assign out_valid      = ov_reg;
    assign result_address = res_addr_reg;
    assign ok             = res_ok_reg;
    assign used_bytes     = res_used_reg;
    assign free_bytes     = res_free_reg;
    assign out_load       = (state_reg == S_OUT) && (!ov_reg || out_ready);

    logic [IW-1:0] enc;
    always_comb
    begin
        enc = '0;
        for (int k = 0; k < MAX_BLOCKS; k++)
            if (hit_first[k])
                enc = enc | IW'(k);
    end

    logic [IW-1:0] ip1;
    assign ip1 = idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= CW'(1);
            ov_reg       <= 1'b0;
            job_reg      <= JOB_NONE;
            job2_reg     <= 1'b0;
            cmd_reg      <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            addr_reg     <= '0;
            ok_reg       <= 1'b0;
            res_addr_reg <= '0;
            res_ok_reg   <= 1'b0;
            res_used_reg <= '0;
            res_free_reg <= '0;
            used_reg     <= '0;
            avail_reg    <= 21'(HEAP_BYTES - HEADER_BYTES);
            for (int k = 0; k < MAX_BLOCKS; k++)
            begin
                fr_reg[k]  <= (k == 0);
                off_reg[k] <= '0;
                sz_reg[k]  <= (k == 0) ? 32'(HEAP_BYTES - HEADER_BYTES) : 32'd0;
            end
        end
        else
        begin
            // result register toward the receiver
            if (out_load)
            begin
                ov_reg       <= 1'b1;
                res_addr_reg <= addr_reg;
                res_ok_reg   <= ok_reg;
                res_used_reg <= used_reg;
                res_free_reg <= avail_reg;
            end
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    idx_reg   <= enc;
                    found_reg <= cmd_reg.valid_op && (hit != '0);
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    ok_reg <= found_reg;
                    if (found_reg && !cmd_reg.is_free)
                    begin
                        fr_reg[idx_reg] <= 1'b0;
                        addr_reg <= heap_start + off_reg[idx_reg] + HDR;
                        job2_reg <= 1'b0;
                        if (sz_reg[idx_reg] >= need32 + SPLIT_MIN &&
                            count_reg < CW'(MAX_BLOCKS))
                        begin
                            sz_reg[idx_reg] <= need32;
                            job_reg <= JOB_OPEN;
                            used_reg  <= used_reg + 21'(need32);
                            avail_reg <= avail_reg - 21'(need32) - 21'(HDR);
                        end
                        else
                        begin
                            job_reg   <= JOB_NONE;
                            used_reg  <= used_reg + 21'(sz_reg[idx_reg]);
                            avail_reg <= avail_reg - 21'(sz_reg[idx_reg]);
                        end
                    end
                    else if (found_reg)
                    begin
                        fr_reg[idx_reg] <= 1'b1;
                        addr_reg  <= 32'd0;
                        used_reg  <= used_reg - 21'(sz_reg[idx_reg]);
                        avail_reg <= avail_reg + 21'(sz_reg[idx_reg]);
                        job_reg   <= (CW'(ip1) < count_reg && ip1 != '0 && fr_reg[ip1]) ?
                                     JOB_MERGE_NEXT : JOB_NONE;
                        job2_reg  <= (idx_reg != '0) && fr_reg[idx_reg - 1'b1];
                    end
                    else
                    begin
                        addr_reg <= 32'd0;
                        job_reg  <= JOB_NONE;
                        job2_reg <= 1'b0;
                    end
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    // one shift of the cell row per cycle
                    priority if (job_reg == JOB_OPEN)
                    begin
                        for (int k = MAX_BLOCKS - 1; k > 0; k--)
                            if (IW'(k) > ip1 && CW'(k) <= count_reg)
                            begin
                                off_reg[k] <= off_reg[k-1];
                                sz_reg[k]  <= sz_reg[k-1];
                                fr_reg[k]  <= fr_reg[k-1];
                            end
                        off_reg[ip1] <= off_reg[idx_reg] + HDR + need32;
                        sz_reg[ip1]  <= split_rem_reg;
                        fr_reg[ip1]  <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        job_reg   <= JOB_NONE;
                    end
                    else if (job_reg == JOB_MERGE_NEXT)
                    begin
                        sz_reg[idx_reg] <= sz_reg[idx_reg] + HDR + sz_reg[ip1];
                        avail_reg <= avail_reg + 21'(HDR);
                        for (int k = 1; k < MAX_BLOCKS - 1; k++)
                            if (IW'(k) >= ip1)
                            begin
                                off_reg[k] <= off_reg[k+1];
                                sz_reg[k]  <= sz_reg[k+1];
                                fr_reg[k]  <= fr_reg[k+1];
                            end
                        count_reg <= count_reg - 1'b1;
                        job_reg   <= JOB_NONE;
                    end
                    else if (job2_reg)
                    begin
                        sz_reg[idx_reg - 1'b1] <= sz_reg[idx_reg - 1'b1] + HDR +
                                                  sz_reg[idx_reg];
                        avail_reg <= avail_reg + 21'(HDR);
                        for (int k = 0; k < MAX_BLOCKS - 1; k++)
                            if (IW'(k) >= idx_reg)
                            begin
                                off_reg[k] <= off_reg[k+1];
                                sz_reg[k]  <= sz_reg[k+1];
                                fr_reg[k]  <= fr_reg[k+1];
                            end
                        count_reg <= count_reg - 1'b1;
                        job2_reg  <= 1'b0;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPLY)
            split_rem_reg <= sz_reg[idx_reg] - need32 - HDR;
    end

endmodule

FILE: hdl/first_fit_block_allocator_core.sv
// first-fit heap block allocator with coalescing
// request channel: valid/ready with func, request_size, free_address
// result channel: out_valid/out_ready with result_address, ok, used_bytes,
//   free_bytes; exactly one result per request, in request order
// the heap start address is written through cfg_we/cfg_wdata; the user
// writes it only while idle, which the block itself does not enforce
// a request passes a two-entry front queue, then the back unit runs
// take, scan, apply, a shift step for each table move (up to two), a
// closing check and a result step; the back takes a new request only
// once the result of the last one is loaded into the output register
// a result waits in its own output register, so the back may finish one
// more request while the receiver stalls; with the front queue full as
// well the input stalls with four requests pending
// reset leaves one free block covering the heap minus one header, a heap
// start of zero and no result pending
module first_fit_block_allocator_core
#(
    parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        valid,
    output logic        ready,
    input  logic        func,
    input  logic [20:0] request_size,
    input  logic [31:0] free_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_address,
    output logic        ok,
    output logic [20:0] used_bytes,
    output logic [20:0] free_bytes
);

    logic [31:0] heap_start_reg;
    logic        cmd_valid, cmd_ready;
    ffba_pkg::ffba_cmd_t cmd;

    // heap start register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heap_start_reg <= 32'd0;
        else if (cfg_we)
            heap_start_reg <= cfg_wdata;
    end

    ffba_front u_front
    (
        .clk(clk), .rst_n(rst_n), .heap_start(heap_start_reg),
        .valid(valid), .ready(ready), .func(func),
        .request_size(request_size), .free_address(free_address),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    ffba_back #(
        .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_back
    (
        .clk(clk), .rst_n(rst_n), .heap_start(heap_start_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_address(result_address), .ok(ok),
        .used_bytes(used_bytes), .free_bytes(free_bytes)
    );

endmodule

FILE: hdl/ffba_checker.sv
module ffba_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_address,
    input logic        ok,
    input logic [20:0] used_bytes,
    input logic [20:0] free_bytes
);

    // out_valid and the result address hold while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_address))
        else $error("result changed under stall");

    // a nonzero address implies success
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_address != 32'd0 |-> ok)
        else $error("address without ok");

    // totals never exceed the default heap size
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, used_bytes} + {1'b0, free_bytes}) <= 22'd1048576)
        else $error("byte totals out of range");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker
(
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .result_address(result_address), .ok(ok),
    .used_bytes(used_bytes), .free_bytes(free_bytes)
);
